// ----- hw/rtl/dpd_pkg.sv -----
// Shared types and constants for the depth pixel deprojection block.
// Used by every module under hw/rtl except dpd_div; depends on nothing else.
package dpd_pkg;

	localparam int COL_W        = 12;
	localparam int DEPTH_W      = 16;
	localparam int QDEPTH_W     = 12;
	localparam int SUM_W        = 15;
	localparam int CNT_W        = 4;
	localparam int WIN_N        = 9;
	localparam int SIZE_W       = 13;
	localparam int PARAM_W      = 16;
	localparam int Z_W          = 20;
	localparam int COORD_W      = 32;
	localparam int CFG_ADDR_W   = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int IN_DATA_W    = 168;
	localparam int OUT_DATA_W   = 88;
	localparam int FIFO_DEPTH   = 4;

	localparam logic [DEPTH_W-1:0] DEPTH_LOW  = 16'd200;
	localparam logic [DEPTH_W-1:0] DEPTH_HIGH = 16'd3000;

	localparam logic [SIZE_W-1:0]  RST_WIDTH  = 13'd640;
	localparam logic [SIZE_W-1:0]  RST_HEIGHT = 13'd480;
	localparam logic [PARAM_W-1:0] RST_FOCAL  = 16'd9600;
	localparam logic [PARAM_W-1:0] RST_PRIN_X = 16'd5120;
	localparam logic [PARAM_W-1:0] RST_PRIN_Y = 16'd3840;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_FOCAL_X      = 3'd2,
		REG_FOCAL_Y      = 3'd3,
		REG_PRINCIPAL_X  = 3'd4,
		REG_PRINCIPAL_Y  = 3'd5
	} dpd_reg_t;

	typedef struct packed {
		logic [SIZE_W-1:0]  image_width;
		logic [SIZE_W-1:0]  image_height;
		logic [PARAM_W-1:0] focal_x;
		logic [PARAM_W-1:0] focal_y;
		logic [PARAM_W-1:0] principal_x;
		logic [PARAM_W-1:0] principal_y;
	} dpd_cfg_t;

	typedef struct packed {
		logic [COL_W-1:0]   column;
		logic [COL_W-1:0]   row;
		logic [DEPTH_W-1:0] centre;
		logic [SUM_W-1:0]   sum;
		logic [CNT_W-1:0]   cnt;
	} dpd_entry_t;

endpackage

// ----- hw/rtl/dpd_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Used by dpd_back; no package dependency.
module dpd_div #(
	parameter int NW = 20,
	parameter int DW = 4,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag,
	output logic          out_valid,
	output logic [NW-1:0] quot,
	output logic [TW-1:0] out_tag
);

	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] nq_s  [NW];
	logic [DW-1:0] den_s [NW];
	logic [TW-1:0] tag_s [NW];
	logic [NW-1:0] v_s;

	for (genvar k = 0; k < NW; k++) begin : g_st
		logic [DW-1:0] rem_i;
		logic [NW-1:0] nq_i;
		logic [DW-1:0] den_i;
		logic [TW-1:0] tag_i;
		logic          v_i;
		logic [DW:0]   t;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_i = '0;
			assign nq_i  = num;
			assign den_i = den;
			assign tag_i = tag;
			assign v_i   = in_valid;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign nq_i  = nq_s[k-1];
			assign den_i = den_s[k-1];
			assign tag_i = tag_s[k-1];
			assign v_i   = v_s[k-1];
		end

		assign t  = {rem_i, nq_i[NW-1]};
		assign ge = t >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(t - {1'b0, den_i}) : t[DW-1:0];
				nq_s[k]  <= {nq_i[NW-2:0], ge};
				den_s[k] <= den_i;
				tag_s[k] <= tag_i;
			end
		end
	end

	assign out_valid = v_s[NW-1];
	assign quot      = nq_s[NW-1];
	assign out_tag   = tag_s[NW-1];

endmodule

// ----- hw/rtl/dpd_front.sv -----
// Input side: takes words, checks the window against image bounds and depth range,
// and pushes a summary entry into the queue. Depends on dpd_pkg.
module dpd_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dpd_pkg::dpd_cfg_t                   cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [dpd_pkg::IN_DATA_W-1:0]       in_data,
	input  logic                                q_full,
	output logic                                push,
	output dpd_pkg::dpd_entry_t                 entry
);

	localparam int W = dpd_pkg::WIN_N;
	localparam logic [1:0] DC [W] = '{2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2};
	localparam logic [1:0] DR [W] = '{2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};

	logic [dpd_pkg::COL_W-1:0]    col_in, row_in;
	logic [2:0]                   col_ok, row_ok;
	logic [dpd_pkg::QDEPTH_W-1:0] qd_in [W];
	logic [W-1:0]                 qm_in;

	logic                         v_s1;
	logic [dpd_pkg::COL_W-1:0]    col_s1, row_s1;
	logic [dpd_pkg::DEPTH_W-1:0]  centre_s1;
	logic [dpd_pkg::QDEPTH_W-1:0] qd_s1 [W];
	logic [W-1:0]                 qm_s1;

	assign col_in = in_data[dpd_pkg::COL_W-1:0];
	assign row_in = in_data[2*dpd_pkg::COL_W-1:dpd_pkg::COL_W];

	always_comb begin
		col_ok[0] = (col_in != '0) && ({1'b0, col_in} - 13'd1 < cfg.image_width);
		col_ok[1] = {1'b0, col_in} < cfg.image_width;
		col_ok[2] = ({1'b0, col_in} + 13'd1) < cfg.image_width;
		row_ok[0] = (row_in != '0) && ({1'b0, row_in} - 13'd1 < cfg.image_height);
		row_ok[1] = {1'b0, row_in} < cfg.image_height;
		row_ok[2] = ({1'b0, row_in} + 13'd1) < cfg.image_height;
	end

	for (genvar i = 0; i < W; i++) begin : g_win
		logic [dpd_pkg::DEPTH_W-1:0] d;
		assign d = in_data[2*dpd_pkg::COL_W + i*dpd_pkg::DEPTH_W +: dpd_pkg::DEPTH_W];
		assign qm_in[i] = col_ok[DC[i]] && row_ok[DR[i]] &&
			(d > dpd_pkg::DEPTH_LOW) && (d < dpd_pkg::DEPTH_HIGH);
		assign qd_in[i] = qm_in[i] ? d[dpd_pkg::QDEPTH_W-1:0] : '0;
	end

	assign in_ready = !v_s1 || !q_full;
	assign push     = v_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			col_s1    <= col_in;
			row_s1    <= row_in;
			centre_s1 <= in_data[2*dpd_pkg::COL_W +: dpd_pkg::DEPTH_W];
			qd_s1     <= qd_in;
			qm_s1     <= qm_in;
		end
	end

	always_comb begin
		entry.column = col_s1;
		entry.row    = row_s1;
		entry.centre = centre_s1;
		entry.sum    = '0;
		entry.cnt    = '0;
		for (int i = 0; i < W; i++) begin
			entry.sum = entry.sum + dpd_pkg::SUM_W'(qd_s1[i]);
			entry.cnt = entry.cnt + dpd_pkg::CNT_W'(qm_s1[i]);
		end
	end

endmodule

// ----- hw/rtl/dpd_fifo.sv -----
// Short queue between the front and back parts of the deprojection block.
// Depends on dpd_pkg for the entry type.
module dpd_fifo #(
	parameter int DEPTH = dpd_pkg::FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dpd_pkg::dpd_entry_t wdata,
	input  logic                pop,
	output dpd_pkg::dpd_entry_t rdata,
	output logic                full,
	output logic                empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dpd_pkg::dpd_entry_t mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

// ----- hw/rtl/dpd_back.sv -----
// Back part: depth averaging divide, lateral products and rounding divides,
// saturation and the output register. Depends on dpd_pkg and dpd_div.
module dpd_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dpd_pkg::dpd_cfg_t                   cfg,
	input  logic                                q_empty,
	input  dpd_pkg::dpd_entry_t                 q_data,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                out_found,
	output logic [dpd_pkg::OUT_DATA_W-1:0]      out_data
);

	localparam int ZW  = dpd_pkg::Z_W;
	localparam int CW  = dpd_pkg::COL_W;
	localparam int PW  = dpd_pkg::PARAM_W;
	localparam int MW  = PW + ZW;
	localparam int NW  = MW + 1;
	localparam int ZTW = 2 * CW + 1;
	localparam int YTW = 3 + ZW;

	logic en;
	logic [ZW-1:0] znum;
	logic [dpd_pkg::CNT_W-1:0] zden;
	logic zfound;
	logic zv;
	logic [ZW-1:0] zq;
	logic [ZTW-1:0] ztag;

	logic v_s1, v_s2, v_s3, vout_q;
	logic [ZW-1:0] z_s1, z_s2, z_s3;
	logic found_s1, found_s2, found_s3;
	logic negx_s1, negy_s1, negx_s2, negy_s2, negx_s3, negy_s3;
	logic [PW-1:0] magx_s1, magy_s1;
	logic [MW-1:0] prodx_s2, prody_s2;
	logic [NW-1:0] numx_s3, numy_s3;
	logic zerox_s3, zeroy_s3;
	logic [PW:0] dx, dy;

	logic xv, yv;
	logic [NW-1:0] qx, qy;
	logic [1:0] xtag;
	logic [YTW-1:0] ytag;
	logic [dpd_pkg::COORD_W-1:0] px, py;

	function automatic logic [dpd_pkg::COORD_W-1:0] sat(input logic [NW-1:0] q,
			input logic neg, input logic zero);
		logic [dpd_pkg::COORD_W-1:0] r;
		if (zero) begin
			r = '0;
		end else if (neg) begin
			r = (q >= NW'(32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - q[31:0]);
		end else begin
			r = (q >= NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
		end
		return r;
	endfunction

	assign en  = !vout_q || out_ready;
	assign pop = en && !q_empty;

	always_comb begin
		zfound = (q_data.centre != '0) || (q_data.cnt != '0);
		if (q_data.centre != '0) begin
			znum = {q_data.centre, 4'b0};
			zden = dpd_pkg::CNT_W'(1);
		end else if (q_data.cnt != '0) begin
			znum = ZW'({q_data.sum, 4'b0}) + ZW'(q_data.cnt[dpd_pkg::CNT_W-1:1]);
			zden = q_data.cnt;
		end else begin
			znum = '0;
			zden = dpd_pkg::CNT_W'(1);
		end
	end

	dpd_div #(.NW(ZW), .DW(dpd_pkg::CNT_W), .TW(ZTW)) u_zdiv (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(!q_empty),
		.num(znum), .den(zden), .tag({q_data.column, q_data.row, zfound}),
		.out_valid(zv), .quot(zq), .out_tag(ztag)
	);

	assign dx = {1'b0, ztag[ZTW-1 -: CW], 4'b0} - {1'b0, cfg.principal_x};
	assign dy = {1'b0, ztag[ZTW-1-CW -: CW], 4'b0} - {1'b0, cfg.principal_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			vout_q <= 1'b0;
		end else if (en) begin
			v_s1   <= zv;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			vout_q <= xv && yv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1     <= zq;
			found_s1 <= ztag[0];
			negx_s1  <= dx[PW];
			negy_s1  <= dy[PW];
			magx_s1  <= dx[PW] ? PW'(-dx) : dx[PW-1:0];
			magy_s1  <= dy[PW] ? PW'(-dy) : dy[PW-1:0];

			z_s2     <= z_s1;
			found_s2 <= found_s1;
			negx_s2  <= negx_s1;
			negy_s2  <= negy_s1;
			prodx_s2 <= magx_s1 * z_s1;
			prody_s2 <= magy_s1 * z_s1;

			z_s3     <= z_s2;
			found_s3 <= found_s2;
			negx_s3  <= negx_s2;
			negy_s3  <= negy_s2;
			zerox_s3 <= prodx_s2 == '0;
			zeroy_s3 <= prody_s2 == '0;
			numx_s3  <= {1'b0, prodx_s2} + NW'(cfg.focal_x[PW-1:1]);
			numy_s3  <= {1'b0, prody_s2} + NW'(cfg.focal_y[PW-1:1]);
		end
	end

	dpd_div #(.NW(NW), .DW(PW), .TW(2)) u_xdiv (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.num(numx_s3), .den(cfg.focal_x), .tag({negx_s3, zerox_s3}),
		.out_valid(xv), .quot(qx), .out_tag(xtag)
	);

	dpd_div #(.NW(NW), .DW(PW), .TW(YTW)) u_ydiv (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.num(numy_s3), .den(cfg.focal_y), .tag({negy_s3, zeroy_s3, found_s3, z_s3}),
		.out_valid(yv), .quot(qy), .out_tag(ytag)
	);

	assign px = sat(qx, xtag[1], xtag[0]);
	assign py = sat(qy, ytag[YTW-1], ytag[YTW-2]);

	always_ff @(posedge clk) begin
		if (en) begin
			out_found <= ytag[ZW];
			out_data  <= {4'b0, ytag[ZW-1:0], py, px};
		end
	end

	assign out_valid = vout_q;

endmodule

// ----- hw/rtl/depth_pixel_deprojection.sv -----
// Top level of the depth pixel deprojection block: configuration registers,
// front part, queue and back part. Depends on dpd_pkg, dpd_front, dpd_fifo and dpd_back.
//
// Each input word on the s_ channel carries a pixel column and row and the 3x3 window
// of millimetre depths around it. Each output word on the m_ channel carries the
// deprojected point X, Y, Z in 1/16 mm, with m_tuser set when a usable depth was found.
// One output word follows every input word, in order.
// Throughput is one word per cycle while m_tready is high. Words pass one front stage,
// the queue, a 20-stage depth divider, three product stages, two 37-stage lateral
// dividers and the output register. Registers must be written by the user via cfg_we,
// cfg_addr and cfg_data only while the block is idle; the block does not enforce this.
// Reset loads the default image size and intrinsics and empties all stages. When the
// receiver holds m_tready low, the back pipeline freezes, the queue fills, and s_tready
// falls once the queue and the front stage are full; nothing is lost.
module depth_pixel_deprojection #(
	parameter int FIFO_DEPTH = dpd_pkg::FIFO_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dpd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [dpd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// column, row, depth_center, depth_up_left, depth_up, depth_up_right,
	// depth_left, depth_right, depth_down_left, depth_down, depth_down_right
	input  logic [dpd_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// point_x, point_y, point_z, zero fill
	output logic [dpd_pkg::OUT_DATA_W-1:0]    m_tdata,
	// found
	output logic                              m_tuser
);

	dpd_pkg::dpd_cfg_t   cfg_q;
	dpd_pkg::dpd_entry_t push_data, pop_data;
	logic push, pop, q_full, q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= dpd_pkg::RST_WIDTH;
			cfg_q.image_height <= dpd_pkg::RST_HEIGHT;
			cfg_q.focal_x      <= dpd_pkg::RST_FOCAL;
			cfg_q.focal_y      <= dpd_pkg::RST_FOCAL;
			cfg_q.principal_x  <= dpd_pkg::RST_PRIN_X;
			cfg_q.principal_y  <= dpd_pkg::RST_PRIN_Y;
		end else if (cfg_we) begin
			case (dpd_pkg::dpd_reg_t'(cfg_addr))
				dpd_pkg::REG_IMAGE_WIDTH: begin
					cfg_q.image_width <= cfg_data[dpd_pkg::SIZE_W-1:0];
				end
				dpd_pkg::REG_IMAGE_HEIGHT: begin
					cfg_q.image_height <= cfg_data[dpd_pkg::SIZE_W-1:0];
				end
				dpd_pkg::REG_FOCAL_X: begin
					cfg_q.focal_x <= cfg_data;
				end
				dpd_pkg::REG_FOCAL_Y: begin
					cfg_q.focal_y <= cfg_data;
				end
				dpd_pkg::REG_PRINCIPAL_X: begin
					cfg_q.principal_x <= cfg_data;
				end
				dpd_pkg::REG_PRINCIPAL_Y: begin
					cfg_q.principal_y <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	dpd_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
		.q_full(q_full), .push(push), .entry(push_data)
	);

	dpd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(push_data),
		.pop(pop), .rdata(pop_data), .full(q_full), .empty(q_empty)
	);

	dpd_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_empty(q_empty), .q_data(pop_data), .pop(pop),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_found(m_tuser), .out_data(m_tdata)
	);

endmodule
